[hdl/dgcd_pkg.sv]
package dgcd_pkg;

	localparam int NODES          = 16;
	localparam int MAX_OUT_DEGREE = 8;

	// node fields are fixed at four bits, so NODES stays within 2**NODE_W
	localparam int NODE_W  = 4;
	localparam int DEG_W   = $clog2(MAX_OUT_DEGREE + 1);
	localparam int EDGE_AW = $clog2(NODES * MAX_OUT_DEGREE);
	localparam int DEPTH_W = $clog2(NODES + 1);
	localparam int STK_AW  = $clog2(NODES);

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_DETECT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] MARK_WHITE = 2'd0;
	localparam logic [1:0] MARK_GRAY  = 2'd1;
	localparam logic [1:0] MARK_BLACK = 2'd2;

	typedef struct packed {
		logic [1:0]        operation;
		logic [NODE_W-1:0] src_node;
		logic [NODE_W-1:0] dst_node;
	} req_t;

	typedef struct packed {
		logic status;
		logic cycle_found;
	} rsp_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [DEG_W-1:0]  next_edge;
	} frame_t;

	typedef struct packed {
		logic add;
		logic clear;
		logic detect;
		logic nop;
		logic edge_step;
		logic check_step;
		logic pop_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic start_ok;
		logic has_edge;
		logic last_frame;
		logic hit_gray;
	} stat_t;

endpackage

[hdl/dgcd_dpath.sv]
module dgcd_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  dgcd_pkg::req_t req,
	input  dgcd_pkg::cmd_t cmd,
	output dgcd_pkg::stat_t stat,
	output dgcd_pkg::rsp_t rsp
);
	import dgcd_pkg::*;

	logic [NODE_W-1:0] adj_mem [NODES*MAX_OUT_DEGREE];
	frame_t            stk_mem [NODES];

	logic [DEG_W-1:0]   deg_q  [NODES];
	logic [1:0]         mark_q [NODES];
	logic [DEPTH_W-1:0] depth_q;

	frame_t            top_q;
	frame_t            stk_rd_q;
	logic [NODE_W-1:0] adj_rd_q;
	rsp_t              res_q;
	rsp_t              rsp_q;

	logic [NODE_W-1:0]  deg_addr;
	logic [DEG_W-1:0]   deg_rd;
	logic               add_ok;
	logic               start_ok;
	logic               has_edge;
	logic               e_ok;
	logic [1:0]         e_mark;
	logic               do_push;
	logic               hit_gray;
	logic [EDGE_AW-1:0] add_addr;
	logic [EDGE_AW-1:0] walk_addr;
	logic [STK_AW-1:0]  push_addr;
	logic [STK_AW-1:0]  pop_addr;

	always_comb begin
		deg_addr  = cmd.add ? req.src_node : top_q.node;
		deg_rd    = deg_q[deg_addr];
		start_ok  = int'(req.src_node) < NODES;
		add_ok    = start_ok && (int'(req.dst_node) < NODES)
			&& (int'(deg_rd) < MAX_OUT_DEGREE);
		has_edge  = (top_q.next_edge < deg_rd) && (int'(top_q.next_edge) < MAX_OUT_DEGREE);
		e_ok      = int'(adj_rd_q) < NODES;
		e_mark    = mark_q[adj_rd_q];
		hit_gray  = e_ok && (e_mark == MARK_GRAY);
		do_push   = cmd.check_step && e_ok && (e_mark == MARK_WHITE) && (int'(depth_q) < NODES);
		add_addr  = EDGE_AW'(int'(req.src_node) * MAX_OUT_DEGREE + int'(deg_rd));
		walk_addr = EDGE_AW'(int'(top_q.node) * MAX_OUT_DEGREE + int'(top_q.next_edge));
		push_addr = STK_AW'(depth_q - DEPTH_W'(1));
		pop_addr  = STK_AW'(depth_q - DEPTH_W'(2));
	end

	assign stat.start_ok   = start_ok;
	assign stat.has_edge   = has_edge;
	assign stat.last_frame = (depth_q == DEPTH_W'(1));
	assign stat.hit_gray   = hit_gray;
	assign rsp             = rsp_q;

	// adjacency lists and the frames below the top of the walk
	always_ff @(posedge clk) begin
		if (cmd.add && add_ok)
			adj_mem[add_addr] <= req.dst_node;
		if (cmd.edge_step)
			adj_rd_q <= adj_mem[walk_addr];
		if (do_push)
			stk_mem[push_addr] <= top_q;
		if (cmd.edge_step)
			stk_rd_q <= stk_mem[pop_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NODES; n++) begin
				deg_q[n]  <= '0;
				mark_q[n] <= MARK_WHITE;
			end
			depth_q <= '0;
		end else begin
			if (cmd.add && add_ok)
				deg_q[req.src_node] <= deg_rd + DEG_W'(1);
			if (cmd.clear) begin
				for (int n = 0; n < NODES; n++) begin
					deg_q[n]  <= '0;
					mark_q[n] <= MARK_WHITE;
				end
				depth_q <= '0;
			end
			if (cmd.detect) begin
				for (int n = 0; n < NODES; n++)
					mark_q[n] <= MARK_WHITE;
				if (start_ok) begin
					mark_q[req.src_node] <= MARK_GRAY;
					depth_q <= DEPTH_W'(1);
				end else begin
					depth_q <= '0;
				end
			end
			if (cmd.edge_step && !has_edge) begin
				mark_q[top_q.node] <= MARK_BLACK;
				depth_q <= depth_q - DEPTH_W'(1);
			end
			if (do_push) begin
				mark_q[adj_rd_q] <= MARK_GRAY;
				depth_q <= depth_q + DEPTH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.detect) begin
			top_q.node      <= req.src_node;
			top_q.next_edge <= '0;
		end
		if (cmd.edge_step && has_edge)
			top_q.next_edge <= top_q.next_edge + DEG_W'(1);
		if (do_push) begin
			top_q.node      <= adj_rd_q;
			top_q.next_edge <= '0;
		end
		if (cmd.pop_step)
			top_q <= stk_rd_q;

		if (cmd.add) begin
			res_q.status      <= !add_ok;
			res_q.cycle_found <= 1'b0;
		end
		if (cmd.clear || cmd.detect || cmd.nop)
			res_q <= '0;
		if (cmd.check_step && hit_gray)
			res_q.cycle_found <= 1'b1;
		if (cmd.load_out)
			rsp_q <= res_q;
	end

endmodule

[hdl/dgcd_ctrl.sv]
module dgcd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [1:0]      operation,
	input  dgcd_pkg::stat_t stat,
	output dgcd_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready
);
	import dgcd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EDGE  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_POP   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DONE;
					unique case (operation)
						OP_ADD:   cmd.add = 1'b1;
						OP_CLEAR: cmd.clear = 1'b1;
						OP_DETECT: begin
							cmd.detect = 1'b1;
							if (stat.start_ok)
								state_d = S_EDGE;
						end
						default:  cmd.nop = 1'b1;
					endcase
				end
			end
			S_EDGE: begin
				cmd.edge_step = 1'b1;
				priority if (stat.has_edge)
					state_d = S_CHECK;
				else if (stat.last_frame)
					state_d = S_DONE;
				else
					state_d = S_POP;
			end
			S_CHECK: begin
				cmd.check_step = 1'b1;
				state_d = stat.hit_gray ? S_DONE : S_EDGE;
			end
			S_POP: begin
				cmd.pop_step = 1'b1;
				state_d = S_EDGE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

[hdl/directed_graph_cycle_detect_top.sv]
// channel | signals                      | payload fields
// req     | req_valid, req_ready, req    | operation, src_node, dst_node
// rsp     | rsp_valid, rsp_ready, rsp    | status, cycle_found
//
// add, clear and unused codes: accepted in S_IDLE, then S_DONE loads the result into the output register
// detect: a depth-first walk from src_node through S_EDGE then S_CHECK for every edge tried,
//   and S_EDGE then S_POP for every node finished but the start node; S_EDGE registers the adjacency read
// reset clears edge counts, marks and the handshake state at once, no clearing pass
// one item at a time; a new item is taken while the previous result waits in the output register
module directed_graph_cycle_detect_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dgcd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dgcd_pkg::rsp_t rsp
);
	import dgcd_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dgcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (req.operation),
		.stat      (stat),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	dgcd_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

[hdl/dgcd_checker.sv]
module dgcd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input dgcd_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input dgcd_pkg::rsp_t rsp
);
	import dgcd_pkg::*;

	// a waiting result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// an accepted item leaves the block busy in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted back to back");

	// a new result only appears while the block is finishing an item
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared while idle");

	// a dropped edge never reports a cycle
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.status && rsp.cycle_found))
		else $error("status and cycle_found both set");

endmodule

bind directed_graph_cycle_detect_top dgcd_checker u_chk (.*);
